/* rtl/tidm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tidm_pkg;

    typedef enum logic {
        OP_ASSIGN = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_IN_USE = 3'd2,
        ST_DUP    = 3'd3,
        ST_NONE   = 3'd4,
        ST_MULTI  = 3'd5
    } t_status;

    // saturating match count carried along the row
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_MANY = 2'd2;

    localparam int FIELD_BITS = 8;

    typedef struct packed {
        t_op                   op;
        logic [FIELD_BITS-1:0] local_id;
        logic [FIELD_BITS-1:0] owner_id;
        logic [FIELD_BITS-1:0] slot;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [3:0] slot_out;
    } t_rsp;

    // control part of the match token handed from cell to cell
    typedef struct packed {
        logic       valid;
        t_op        op;
        logic       in_use;
        logic [1:0] count;
    } t_ctl;

endpackage

`default_nettype wire

/* rtl/tidm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module tidm_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4,
    parameter int KW    = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tidm_pkg::t_ctl                i_ctl,
    input  wire logic [KW-1:0]                 i_key,
    input  wire logic [tidm_pkg::FIELD_BITS-1:0] i_slot,
    input  wire logic [IDX_W-1:0]              i_where,
    output tidm_pkg::t_ctl                     o_ctl,
    output logic [KW-1:0]                      o_key,
    output logic [tidm_pkg::FIELD_BITS-1:0]    o_slot,
    output logic [IDX_W-1:0]                   o_where,
    input  wire logic                          i_wr_en,
    input  wire logic [IDX_W-1:0]              i_wr_slot,
    input  wire logic [KW-1:0]                 i_wr_key
);
    import tidm_pkg::*;

    logic                  r_valid;
    logic [KW-1:0]         r_key;
    t_ctl                  r_ctl;
    t_ctl                  n_ctl;
    logic [KW-1:0]         r_tkey;
    logic [FIELD_BITS-1:0] r_tslot;
    logic [IDX_W-1:0]      r_where;
    logic [IDX_W-1:0]      n_where;
    logic                  hit;
    logic                  mine;

    assign hit  = r_valid && (r_key == i_key);
    assign mine = (i_slot == FIELD_BITS'(INDEX));

    always_comb begin
        n_ctl   = i_ctl;
        n_where = i_where;
        if (hit) begin
            n_ctl.count = (i_ctl.count == CNT_NONE) ? CNT_ONE : CNT_MANY;
            n_where     = IDX_W'(INDEX);
        end
        if (i_ctl.op == OP_ASSIGN && mine && r_valid) begin
            n_ctl.in_use = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (i_wr_en && i_wr_slot == IDX_W'(INDEX)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tkey  <= i_key;
        r_tslot <= i_slot;
        r_where <= n_where;
        if (i_wr_en && i_wr_slot == IDX_W'(INDEX)) begin
            r_key <= i_wr_key;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_key   = r_tkey;
    assign o_slot  = r_tslot;
    assign o_where = r_where;

endmodule

`default_nettype wire

/* rtl/thread_id_map_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Thread id map table. Each slot is a cell in a row; an item's key walks the
// row one cell per clock, collecting the match count, the last matching slot
// and whether the target slot is taken. Each cell registers the item in turn,
// and the result register and o_done follow the last cell. busy is set when
// an item is accepted and cleared as it leaves the last cell, so a new item
// can start in the strobe cycle but not while one is in the row. Assign writes the key
// into its slot at the edge that registers the result. The result is flagged
// by o_done, high for a single cycle, and must be taken then; o_rsp holds it
// until the next result is registered. Reset clears every slot's valid bit at once.
module thread_id_map_table_top #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tidm_pkg::t_req i_req,
    output logic                o_done,
    output tidm_pkg::t_rsp      o_rsp
);
    import tidm_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int KB    = (ID_BITS < FIELD_BITS) ? ID_BITS : FIELD_BITS;
    localparam int KW    = 2 * KB;
    localparam logic [FIELD_BITS:0] SLOT_LIM = (FIELD_BITS + 1)'(SLOTS);

    t_ctl                  tok_ctl   [SLOTS+1];
    logic [KW-1:0]         tok_key   [SLOTS+1];
    logic [FIELD_BITS-1:0] tok_slot  [SLOTS+1];
    logic [IDX_W-1:0]      tok_where [SLOTS+1];

    logic                  r_busy;
    logic                  r_done;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;
    logic                  wr_en;
    logic [IDX_W-1:0]      res;
    logic [IDX_W+3:0]      res_ext;
    t_ctl                  last;

    always_comb begin
        tok_ctl[0].valid  = start && !r_busy;
        tok_ctl[0].op     = i_req.op;
        tok_ctl[0].in_use = 1'b0;
        tok_ctl[0].count  = CNT_NONE;
    end
    assign tok_key[0]   = {i_req.owner_id[KB-1:0], i_req.local_id[KB-1:0]};
    assign tok_slot[0]  = i_req.slot;
    assign tok_where[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tidm_cell #(
            .INDEX (g),
            .IDX_W (IDX_W),
            .KW    (KW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (tok_ctl[g]),
            .i_key     (tok_key[g]),
            .i_slot    (tok_slot[g]),
            .i_where   (tok_where[g]),
            .o_ctl     (tok_ctl[g+1]),
            .o_key     (tok_key[g+1]),
            .o_slot    (tok_slot[g+1]),
            .o_where   (tok_where[g+1]),
            .i_wr_en   (wr_en),
            .i_wr_slot (tok_slot[SLOTS][IDX_W-1:0]),
            .i_wr_key  (tok_key[SLOTS])
        );
    end

    assign last = tok_ctl[SLOTS];

    always_comb begin
        wr_en        = 1'b0;
        res          = '0;
        n_rsp.status = ST_OK;
        if (last.op == OP_ASSIGN) begin
            if ({1'b0, tok_slot[SLOTS]} >= SLOT_LIM) begin
                n_rsp.status = ST_RANGE;
            end else if (last.in_use) begin
                n_rsp.status = ST_IN_USE;
            end else if (last.count != CNT_NONE) begin
                n_rsp.status = ST_DUP;
            end else begin
                wr_en = last.valid;
                res   = tok_slot[SLOTS][IDX_W-1:0];
            end
        end else begin
            if (last.count == CNT_NONE) begin
                n_rsp.status = ST_NONE;
            end else if (last.count == CNT_MANY) begin
                n_rsp.status = ST_MULTI;
            end else begin
                res = tok_where[SLOTS];
            end
        end
        res_ext        = {4'b0000, res};
        n_rsp.slot_out = res_ext[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= last.valid;
            if (last.valid) begin
                r_busy <= 1'b0;
            end else if (start && !r_busy) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (last.valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

/* rtl/tidm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tidm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_done,
    input wire tidm_pkg::t_rsp o_rsp
);
    import tidm_pkg::*;

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    // the strobe only follows a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding item");

    // one strobe per item, never two in a row
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

    // failed items report slot zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status != ST_OK |-> o_rsp.slot_out == 4'd0)
        else $error("nonzero slot on failed item");

endmodule

bind thread_id_map_table_top tidm_checker u_tidm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire
